// ===== sv/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared widths and constants of the LZ77 window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // History window.
  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);

  // Payload widths.
  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 32;

  // Match length: low nibble plus the minimum match.
  localparam int MIN_MATCH   = 3;
  localparam int CNT_W       = 5;

  // Configuration port.
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // Register indexes (word address, paddr[2]).
  localparam logic REG_RAW_SIZE = 1'b0;

endpackage

// ===== sv/lzwd_if.sv =====
// ----------------------------------------------------------------------------
// lzwd_in_if / lzwd_out_if
// Valid/ready channels that carry packed bytes in and decoded bytes out.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic                          valid;
  logic                          ready;
  logic [lzwd_pkg::BYTE_W-1:0]   packed_byte;
  logic                          stream_start;

  modport source (output valid, output packed_byte, output stream_start, input ready);
  modport sink   (input valid, input packed_byte, input stream_start, output ready);
endinterface

interface lzwd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lzwd_pkg::BYTE_W-1:0]   out_byte;
  logic                          run_last;
  logic                          data_end;

  modport source (output valid, output out_byte, output run_last, output data_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input data_end,
                  output ready);
endinterface

// ===== sv/lz77_window_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lz77_window_decoder_core
// LZSS decoder with a 4096-byte history: flag bytes, literals and matches.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Carries
//  in_if     in         valid/ready          packed_byte, stream_start
//  out_if    out        valid/ready          out_byte, run_last, data_end
//  cfg_*     in         APB write/read       raw_size at byte address 0
//
//  A flag byte, a first match byte or an ignored item is consumed in the idle state.
//  A literal goes to the emit step; a match runs a read step and an emit step per copied byte,
//  since each copied byte goes through the history RAM's registered read
//  and then its write in the emit step.
//  rst_n clears the control state; the history RAM is not cleared.
//  A stalled output holds the emit step until the output register frees up.
// ----------------------------------------------------------------------------
module lz77_window_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  lzwd_in_if.sink                       in_if,
  lzwd_out_if.source                    out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lzwd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [lzwd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lzwd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int BW = lzwd_pkg::BYTE_W;
  localparam int SW = lzwd_pkg::SIZE_W;
  localparam int AW = lzwd_pkg::WIN_AW;
  localparam int CW = lzwd_pkg::CNT_W;
  localparam int DW = lzwd_pkg::WIN_AW + 1;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // Parse phases.
  localparam logic [1:0] PH_FLAG   = 2'd0;
  localparam logic [1:0] PH_TOKEN  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    flag_shift_r, flag_shift_nxt;
  logic [3:0]    flags_left_r, flags_left_nxt;
  logic [BW-1:0] held_r, held_nxt;
  logic [SW-1:0] bw_r, bw_nxt;
  logic [SW-1:0] raw_size_r;
  logic [DW-1:0] dist_r, dist_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          lit_r, lit_nxt;
  logic [BW-1:0] lit_byte_r, lit_byte_nxt;
  logic          zero_r, zero_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_byte_r;
  logic          run_last_r;
  logic          data_end_r;

  logic          in_acc;
  logic [1:0]    ph_eff;
  logic [7:0]    fs_eff;
  logic [3:0]    fl_eff;
  logic [SW-1:0] bw_eff;
  logic          done_eff;
  logic [SW-1:0] room;
  logic [AW-1:0] dist_low;
  logic [DW-1:0] dist_full;
  logic [CW-1:0] len;
  logic [3:0]    fl_dec;

  logic          fire;
  logic [BW-1:0] emit_byte;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] ram_rdata;
  logic          ram_we;

  // Configuration port: one register, written in the APB access phase.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == lzwd_pkg::REG_RAW_SIZE) ? raw_size_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_size_r <= SW'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == lzwd_pkg::REG_RAW_SIZE)) begin
      raw_size_r <= cfg_pwdata;
    end
  end

  // Input side: the decoder takes an item only while the sequencer is idle.
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  // Stream start clears the parse state before the item is looked at.
  assign ph_eff   = in_if.stream_start ? PH_FLAG : phase_r;
  assign fs_eff   = in_if.stream_start ? 8'd0    : flag_shift_r;
  assign fl_eff   = in_if.stream_start ? 4'd0    : flags_left_r;
  assign bw_eff   = in_if.stream_start ? '0      : bw_r;
  assign done_eff = (bw_eff >= raw_size_r);
  assign fl_dec   = fl_eff - 4'd1;

  // Match decode from the held first byte and the second byte.
  assign room      = raw_size_r - bw_eff;
  assign dist_low  = {held_r[7:4], in_if.packed_byte};
  assign dist_full = (dist_low == '0) ? DW'(lzwd_pkg::WINDOW_SIZE) : {1'b0, dist_low};
  assign len       = CW'(held_r[3:0]) + CW'(lzwd_pkg::MIN_MATCH);

  // Emit step moves when the output register is empty or being drained.
  assign fire      = (!out_valid_r) || out_if.ready;
  assign emit_byte = lit_r ? lit_byte_r : (zero_r ? '0 : ram_rdata);

  // Source address of the next copied byte, modulo the window.
  assign rd_addr = bw_r[AW-1:0] - dist_r[AW-1:0];
  assign ram_we  = (state_r == ST_EMIT) && fire;

  // Sequencer and parse state.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    flag_shift_nxt = flag_shift_r;
    flags_left_nxt = flags_left_r;
    held_nxt       = held_r;
    bw_nxt         = bw_r;
    dist_nxt       = dist_r;
    cnt_nxt        = cnt_r;
    lit_nxt        = lit_r;
    lit_byte_nxt   = lit_byte_r;
    zero_nxt       = zero_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          phase_nxt      = ph_eff;
          flag_shift_nxt = fs_eff;
          flags_left_nxt = fl_eff;
          bw_nxt         = bw_eff;
          if (in_if.stream_start) begin
            held_nxt = '0;
          end
          if (!done_eff) begin
            unique case (ph_eff)
              PH_FLAG: begin
                flag_shift_nxt = in_if.packed_byte;
                flags_left_nxt = 4'd8;
                phase_nxt      = PH_TOKEN;
              end
              PH_TOKEN: begin
                flag_shift_nxt = {fs_eff[6:0], 1'b0};
                flags_left_nxt = fl_dec;
                if (!fs_eff[7]) begin
                  // Literal: one byte straight to the emit step.
                  lit_nxt      = 1'b1;
                  lit_byte_nxt = in_if.packed_byte;
                  cnt_nxt      = CW'(1);
                  state_nxt    = ST_EMIT;
                  phase_nxt    = (fl_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                end else begin
                  held_nxt  = in_if.packed_byte;
                  phase_nxt = PH_SECOND;
                end
              end
              PH_SECOND: begin
                // Match: clip the length to the room left in the output.
                lit_nxt   = 1'b0;
                dist_nxt  = dist_full;
                cnt_nxt   = (room < SW'(len)) ? room[CW-1:0] : len;
                state_nxt = ST_READ;
                phase_nxt = (flags_left_r != 4'd0) ? PH_TOKEN : PH_FLAG;
              end
              default: begin
                phase_nxt = PH_FLAG;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        // History before the start of output reads as zero.
        zero_nxt  = (SW'(dist_r) > bw_r);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (fire) begin
          bw_nxt  = bw_r + SW'(1);
          cnt_nxt = cnt_r - CW'(1);
          state_nxt = (cnt_r == CW'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ram_we) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_FLAG;
      flag_shift_r <= '0;
      flags_left_r <= '0;
      held_r       <= '0;
      bw_r         <= '0;
      cnt_r        <= '0;
      lit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flag_shift_r <= flag_shift_nxt;
      flags_left_r <= flags_left_nxt;
      held_r       <= held_nxt;
      bw_r         <= bw_nxt;
      cnt_r        <= cnt_nxt;
      lit_r        <= lit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    lit_byte_r <= lit_byte_nxt;
    zero_r     <= zero_nxt;
    if (ram_we) begin
      out_byte_r <= emit_byte;
      run_last_r <= (cnt_r == CW'(1));
      data_end_r <= ((bw_r + SW'(1)) == raw_size_r);
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.run_last = run_last_r;
  assign out_if.data_end = data_end_r;

  // History window.
  lzwd_ram #(
    .WIDTH (BW),
    .DEPTH (lzwd_pkg::WINDOW_SIZE)
  ) u_hist (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (bw_r[AW-1:0]),
    .wdata   (emit_byte),
    .raddr   (rd_addr),
    .rdata_r (ram_rdata)
  );

endmodule

// ===== sv/lzwd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ===== sv/lzwd_checker.sv =====
// ----------------------------------------------------------------------------
// lzwd_checker
// Port-level checks of the LZ77 window decoder, bound to its top level.
// ----------------------------------------------------------------------------
module lzwd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lzwd_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_run_last,
  input logic                        out_data_end
);

  // A stalled output item keeps its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output item changed while stalled");

  // The item that completes the output also ends its run.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_end |-> out_run_last)
    else $error("data_end without run_last");

  // While a run is still going, no new input item is taken.
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input ready in the middle of a run");

endmodule

bind lz77_window_decoder_core lzwd_checker u_lzwd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_byte     (out_if.out_byte),
  .out_run_last (out_if.run_last),
  .out_data_end (out_if.data_end)
);
